@@ rtl/core/mcdt_pkg.sv @@
// Shared types and constants for the multi-channel down timer.
`timescale 1ns / 1ps

package mcdt_pkg;

    // Field widths fixed by the command and result word formats.
    localparam int CMD_W  = 4;
    localparam int ID_W   = 4;
    localparam int VAL_W  = 16;
    localparam int KIND_W = 2;

    // At most this many expiry events are reported for one tick.
    localparam int MAX_EVENTS = 16;
    localparam int EV_W       = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK        = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ARM         = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SET_ENABLE  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD_COUNT  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SET_RELOAD  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_READ_COUNT  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_READ_RELOAD = 4'd7;
    localparam logic [CMD_W-1:0] CMD_READ_FLAG   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_READ_CLEAR  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_CLEAR_FLAG  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_READ_ENABLE = 4'd11;
    localparam logic [CMD_W-1:0] CMD_DISARM      = 4'd12;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

    // One command word.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  timer_id;
        logic [VAL_W-1:0] time_value;
        logic [VAL_W-1:0] reload_value;
        logic             periodic;
        logic             enable;
    } cmd_word_t;

    // One result word.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   timer_id_res;
        logic [VAL_W-1:0]  value;
        logic              flag;
        logic              running;
        logic              last;
    } res_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic tick_start;
        logic tick_step;
        logic exec_cmd;
        logic emit_done;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic scan_last;
        logic emit_pending;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/core/mcdt_datapath.sv @@
// Datapath of the down timer: channel storage, tick scan counters and result register.
`timescale 1ns / 1ps

module mcdt_datapath #(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mcdt_pkg::cmd_word_t cmd_word,
    input  logic               res_ready,
    output logic               res_valid,
    output mcdt_pkg::res_word_t res_word,
    input  mcdt_pkg::ctrl_t    ctrl,
    output mcdt_pkg::stat_t    stat
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = COUNT_WIDTH;

    // Latched command word.
    mcdt_pkg::cmd_word_t cmd_reg;

    // Tick scan state.
    logic [IW-1:0]                 idx_reg, idx_next;
    logic [mcdt_pkg::EV_W-1:0]     ev_cnt_reg, ev_cnt_next;
    logic [mcdt_pkg::VAL_W-1:0]    exp_cnt_reg, exp_cnt_next;

    // Channel storage: count and reload in a memory, flags in flip-flops.
    logic [2*CW-1:0]               mem [NUM_TIMERS];
    logic [2*CW-1:0]               rd_data_reg;
    logic                          rd_vld_reg;
    logic [NUM_TIMERS-1:0]         vld_reg, per_reg, en_reg, flag_reg;

    // Result register.
    logic                          res_valid_reg, res_valid_next;
    mcdt_pkg::res_word_t           res_word_reg, res_word_next;

    logic [31:0]   id32, tv32, rv32, idx32, reply32, ev32;
    logic [IW-1:0] cmd_addr, act_addr, rd_addr;
    logic          in_range, is_tick, scan_last;
    logic [CW-1:0] tv, rv, cur_count, cur_reload;
    logic          cur_per, cur_en, cur_flag;

    // Command results.
    logic [CW-1:0] c_count, c_reload;
    logic          c_per, c_en, c_flag, show_reload;

    // Tick results.
    logic [CW-1:0] t_dec, t_count;
    logic          t_active, t_expire, t_en, t_flag, emit_pending;

    // Write-back values.
    logic          wr_en;
    logic [CW-1:0] w_count, w_reload;
    logic          w_per, w_en, w_flag;
    logic          out_free;

    // Decode of the latched command.
    assign id32      = 32'(cmd_reg.timer_id);
    assign cmd_addr  = id32[IW-1:0];
    assign in_range  = id32 < 32'(NUM_TIMERS);
    assign is_tick   = (cmd_reg.command == mcdt_pkg::CMD_TICK);
    assign tv32      = 32'(cmd_reg.time_value);
    assign rv32      = 32'(cmd_reg.reload_value);
    assign tv        = tv32[CW-1:0];
    assign rv        = rv32[CW-1:0];
    assign idx32     = 32'(idx_reg);
    assign scan_last = (idx32 == 32'(NUM_TIMERS - 1));
    assign act_addr  = is_tick ? idx_reg : cmd_addr;

    // Read address: look one channel ahead while the scan advances.
    always_comb
    begin
        if (!is_tick)
        begin
            rd_addr = cmd_addr;
        end
        else if (ctrl.tick_start)
        begin
            rd_addr = '0;
        end
        else if (ctrl.tick_step && !scan_last)
        begin
            rd_addr = idx_reg + IW'(1);
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    // Current channel state; an entry never written reads as zero.
    assign cur_count  = rd_vld_reg ? rd_data_reg[CW-1:0] : '0;
    assign cur_reload = rd_vld_reg ? rd_data_reg[2*CW-1:CW] : '0;
    assign cur_per    = per_reg[act_addr];
    assign cur_en     = en_reg[act_addr];
    assign cur_flag   = flag_reg[act_addr];

    // Effect of a channel command.
    always_comb
    begin
        c_count     = cur_count;
        c_reload    = cur_reload;
        c_per       = cur_per;
        c_en        = cur_en;
        c_flag      = cur_flag;
        show_reload = 1'b0;
        unique case (cmd_reg.command)
            mcdt_pkg::CMD_ARM:
            begin
                c_count  = tv;
                c_reload = rv;
                c_per    = cmd_reg.periodic;
                c_flag   = 1'b0;
                c_en     = cmd_reg.enable;
            end
            mcdt_pkg::CMD_SET_ENABLE:
            begin
                c_en = cmd_reg.enable;
            end
            mcdt_pkg::CMD_RESTART:
            begin
                c_count = cur_reload;
                c_flag  = 1'b0;
                c_en    = 1'b1;
            end
            mcdt_pkg::CMD_LOAD_COUNT:
            begin
                c_count = tv;
                c_flag  = 1'b0;
                c_en    = cmd_reg.enable;
            end
            mcdt_pkg::CMD_SET_RELOAD:
            begin
                c_reload    = rv;
                show_reload = 1'b1;
            end
            mcdt_pkg::CMD_READ_RELOAD:
            begin
                show_reload = 1'b1;
            end
            mcdt_pkg::CMD_READ_CLEAR, mcdt_pkg::CMD_CLEAR_FLAG:
            begin
                c_flag = 1'b0;
            end
            mcdt_pkg::CMD_DISARM:
            begin
                c_count  = '0;
                c_reload = '0;
                c_per    = 1'b0;
                c_en     = 1'b0;
                c_flag   = 1'b0;
            end
            mcdt_pkg::CMD_READ_COUNT, mcdt_pkg::CMD_READ_FLAG,
            mcdt_pkg::CMD_READ_ENABLE:
            begin
                show_reload = 1'b0;
            end
            default:
            begin
                show_reload = 1'b0;
            end
        endcase
    end

    // Effect of a tick on the channel under the scan.
    assign t_active     = cur_en && (cur_count != '0);
    assign t_dec        = cur_count - CW'(1);
    assign t_expire     = t_active && (t_dec == '0);
    assign t_count      = t_expire ? (cur_per ? cur_reload : '0)
                                   : (t_active ? t_dec : cur_count);
    assign t_en         = (t_expire && !cur_per) ? 1'b0 : cur_en;
    assign t_flag       = t_expire ? 1'b1 : cur_flag;
    assign emit_pending = t_expire && (ev_cnt_reg < mcdt_pkg::EV_W'(mcdt_pkg::MAX_EVENTS));

    // Write-back selection.
    assign wr_en    = (ctrl.exec_cmd && in_range) || ctrl.tick_step;
    assign w_count  = is_tick ? t_count : c_count;
    assign w_reload = is_tick ? cur_reload : c_reload;
    assign w_per    = is_tick ? cur_per : c_per;
    assign w_en     = is_tick ? t_en : c_en;
    assign w_flag   = is_tick ? t_flag : c_flag;

    // Count and reload memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[act_addr] <= {w_reload, w_count};
        end
        rd_data_reg <= mem[rd_addr];
        if (ctrl.load)
        begin
            cmd_reg <= cmd_word;
        end
        res_word_reg <= res_word_next;
    end

    // Per-channel flag bits and the valid bit of each memory entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            per_reg    <= '0;
            en_reg     <= '0;
            flag_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (wr_en)
            begin
                vld_reg[act_addr]  <= 1'b1;
                per_reg[act_addr]  <= w_per;
                en_reg[act_addr]   <= w_en;
                flag_reg[act_addr] <= w_flag;
            end
        end
    end

    // Scan index, event count and saturating expiry count.
    always_comb
    begin
        idx_next     = idx_reg;
        ev_cnt_next  = ev_cnt_reg;
        exp_cnt_next = exp_cnt_reg;
        if (ctrl.tick_start)
        begin
            idx_next     = '0;
            ev_cnt_next  = '0;
            exp_cnt_next = '0;
        end
        else if (ctrl.tick_step)
        begin
            idx_next = idx_reg + IW'(1);
            if (t_expire && (exp_cnt_reg != '1))
            begin
                exp_cnt_next = exp_cnt_reg + 16'd1;
            end
            if (emit_pending)
            begin
                ev_cnt_next = ev_cnt_reg + mcdt_pkg::EV_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            ev_cnt_reg    <= '0;
            exp_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            ev_cnt_reg    <= ev_cnt_next;
            exp_cnt_reg   <= exp_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result word assembly; the controller only emits when the register is free.
    assign out_free = !res_valid_reg || res_ready;
    assign reply32  = 32'(show_reload ? c_reload : c_count);
    assign ev32     = 32'(t_count);

    always_comb
    begin
        res_word_next  = res_word_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (ctrl.exec_cmd)
        begin
            res_valid_next             = 1'b1;
            res_word_next.kind         = mcdt_pkg::KIND_REPLY;
            res_word_next.timer_id_res = cmd_reg.timer_id;
            res_word_next.last         = 1'b1;
            if (in_range)
            begin
                res_word_next.value   = reply32[mcdt_pkg::VAL_W-1:0];
                res_word_next.flag    = cur_flag;
                res_word_next.running = c_en;
            end
            else
            begin
                res_word_next.value   = '0;
                res_word_next.flag    = 1'b0;
                res_word_next.running = 1'b0;
            end
        end
        else if (ctrl.tick_step && emit_pending)
        begin
            res_valid_next             = 1'b1;
            res_word_next.kind         = mcdt_pkg::KIND_EXPIRY;
            res_word_next.timer_id_res = idx32[mcdt_pkg::ID_W-1:0];
            res_word_next.value        = ev32[mcdt_pkg::VAL_W-1:0];
            res_word_next.flag         = 1'b1;
            res_word_next.running      = t_en;
            res_word_next.last         = 1'b0;
        end
        else if (ctrl.emit_done)
        begin
            res_valid_next             = 1'b1;
            res_word_next.kind         = mcdt_pkg::KIND_DONE;
            res_word_next.timer_id_res = '0;
            res_word_next.value        = exp_cnt_reg;
            res_word_next.flag         = 1'b0;
            res_word_next.running      = 1'b0;
            res_word_next.last         = 1'b1;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // Status back to the controller.
    assign stat.is_tick      = is_tick;
    assign stat.scan_last    = scan_last;
    assign stat.emit_pending = emit_pending;
    assign stat.out_free     = out_free;

endmodule

@@ rtl/core/mcdt_ctrl.sv @@
// Controller state machine of the down timer: command sequencing and tick scan.
`timescale 1ns / 1ps

module mcdt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  mcdt_pkg::stat_t stat,
    output mcdt_pkg::ctrl_t ctrl
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_CMD  = 5'b00100,
        S_TICK = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        cmd_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // Channel state is fetched here; a tick also clears its counters.
                if (stat.is_tick)
                begin
                    ctrl.tick_start = 1'b1;
                    state_next      = S_TICK;
                end
                else
                begin
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                if (stat.out_free)
                begin
                    ctrl.exec_cmd = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TICK:
            begin
                // Hold the scan while an expiry event waits for the result register.
                if (stat.out_free || !stat.emit_pending)
                begin
                    ctrl.tick_step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.emit_done = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/multi_channel_down_timer.sv @@
// Top level of the multi-channel down timer: controller and datapath.
//
//   Channel   Direction  Word type   Handshake
//   cmd       in         cmd_word_t  cmd_valid / cmd_ready
//   res       out        res_word_t  res_valid / res_ready
//
// A channel command goes from acceptance to its reply in the result register
// through accept, memory read and execute. A tick scans the channels in order
// through the read port and the write port of the count and reload memory, one
// channel per cycle unless an expiry event waits for a stalled result register.
// Reset clears every channel to count 0, reload 0, one-shot, disabled, flag clear.
// A stalled result register holds the scan at the next expiring channel.
`timescale 1ns / 1ps

module multi_channel_down_timer #(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  mcdt_pkg::cmd_word_t cmd_word,
    output logic                res_valid,
    input  logic                res_ready,
    output mcdt_pkg::res_word_t res_word
);

    mcdt_pkg::ctrl_t ctrl;
    mcdt_pkg::stat_t stat;

    // Sequencing.
    mcdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Storage and arithmetic.
    mcdt_datapath #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_word  (res_word),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule

@@ rtl/core/mcdt_checker.sv @@
// Port-level checker for the multi-channel down timer and its bind.
`timescale 1ns / 1ps

module mcdt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                res_valid,
    input logic                res_ready,
    input mcdt_pkg::res_word_t res_word
);

    // A result word stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped before acceptance");

    // The block works on one command word at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted while the previous one is in progress");

    // A tick summary closes the item and carries no channel status.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_word.kind == mcdt_pkg::KIND_DONE) |->
        res_word.last && !res_word.flag && !res_word.running
        && (res_word.timer_id_res == '0))
        else $error("malformed tick summary");

    // An expiry event always shows the flag and never closes the item.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_word.kind == mcdt_pkg::KIND_EXPIRY) |->
        res_word.flag && !res_word.last)
        else $error("malformed expiry event");

endmodule

bind multi_channel_down_timer mcdt_checker u_mcdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
);

@@ sim/timer_bank_check.sv @@
// Result checker for the multi-channel down timer: predicts every result word and compares.
`timescale 1ns / 1ps

module timer_bank_check #(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_ready,
    input  mcdt_pkg::cmd_word_t cmd_word,
    input  logic                res_valid,
    input  logic                res_ready,
    input  mcdt_pkg::res_word_t res_word,
    output int                  mismatches,
    output int                  outstanding
);

    import mcdt_pkg::*;

    // Shadow copy of the channel bank.
    logic [COUNT_WIDTH-1:0] ch_count   [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] ch_reload  [NUM_TIMERS];
    logic                   ch_periodic[NUM_TIMERS];
    logic                   ch_enabled [NUM_TIMERS];
    logic                   ch_flag    [NUM_TIMERS];

    // Result words still owed by the block, oldest first.
    res_word_t due_words[$];
    res_word_t want;
    int        bad_count;

    // Work out the result words of one command word and queue them.
    task automatic apply_command(input cmd_word_t w);
        res_word_t        r;
        int unsigned      fired;
        int unsigned      shown;
        int               i;
        logic [COUNT_WIDTH-1:0] tv;
        logic [COUNT_WIDTH-1:0] rv;
        logic             flag_before;
        logic             show_reload;
        begin
            tv = COUNT_WIDTH'(w.time_value);
            rv = COUNT_WIDTH'(w.reload_value);
            r  = '0;
            if (w.command == CMD_TICK)
            begin
                // Walk the channels in index order, one expiry word per channel that fires, up to MAX_EVENTS.
                fired = 0;
                shown = 0;
                for (i = 0; i < NUM_TIMERS; i++)
                begin
                    if (ch_enabled[i] && ch_count[i] != '0)
                    begin
                        ch_count[i] = ch_count[i] - 1'b1;
                        if (ch_count[i] == '0)
                        begin
                            ch_flag[i] = 1'b1;
                            if (ch_periodic[i])
                                ch_count[i] = ch_reload[i];
                            else
                                ch_enabled[i] = 1'b0;
                            if (fired < 16'hFFFF)
                                fired++;
                            if (shown < MAX_EVENTS)
                            begin
                                r.kind         = KIND_EXPIRY;
                                r.timer_id_res = ID_W'(i);
                                r.value        = VAL_W'(ch_count[i]);
                                r.flag         = 1'b1;
                                r.running      = ch_enabled[i];
                                r.last         = 1'b0;
                                due_words.push_back(r);
                                shown++;
                            end
                        end
                    end
                end
                r.kind         = KIND_DONE;
                r.timer_id_res = '0;
                r.value        = VAL_W'(fired);
                r.flag         = 1'b0;
                r.running      = 1'b0;
                r.last         = 1'b1;
                due_words.push_back(r);
            end
            else if (int'(w.timer_id) >= NUM_TIMERS)
            begin
                // A channel that does not exist answers with an empty reply.
                r.kind         = KIND_REPLY;
                r.timer_id_res = w.timer_id;
                r.last         = 1'b1;
                due_words.push_back(r);
            end
            else
            begin
                flag_before = ch_flag[w.timer_id];
                show_reload = 1'b0;
                case (w.command)
                    CMD_ARM:
                    begin
                        ch_count[w.timer_id]    = tv;
                        ch_reload[w.timer_id]   = rv;
                        ch_periodic[w.timer_id] = w.periodic;
                        ch_flag[w.timer_id]     = 1'b0;
                        ch_enabled[w.timer_id]  = w.enable;
                    end
                    CMD_SET_ENABLE:
                        ch_enabled[w.timer_id] = w.enable;
                    CMD_RESTART:
                    begin
                        ch_count[w.timer_id]   = ch_reload[w.timer_id];
                        ch_flag[w.timer_id]    = 1'b0;
                        ch_enabled[w.timer_id] = 1'b1;
                    end
                    CMD_LOAD_COUNT:
                    begin
                        ch_count[w.timer_id]   = tv;
                        ch_flag[w.timer_id]    = 1'b0;
                        ch_enabled[w.timer_id] = w.enable;
                    end
                    CMD_SET_RELOAD:
                    begin
                        ch_reload[w.timer_id] = rv;
                        show_reload = 1'b1;
                    end
                    CMD_READ_RELOAD:
                        show_reload = 1'b1;
                    CMD_READ_CLEAR, CMD_CLEAR_FLAG:
                        ch_flag[w.timer_id] = 1'b0;
                    CMD_DISARM:
                    begin
                        ch_count[w.timer_id]    = '0;
                        ch_reload[w.timer_id]   = '0;
                        ch_periodic[w.timer_id] = 1'b0;
                        ch_enabled[w.timer_id]  = 1'b0;
                        ch_flag[w.timer_id]     = 1'b0;
                    end
                    // Reads and unknown codes leave the channel alone.
                    default: ;
                endcase
                r.kind         = KIND_REPLY;
                r.timer_id_res = w.timer_id;
                r.value        = show_reload ? VAL_W'(ch_reload[w.timer_id])
                                             : VAL_W'(ch_count[w.timer_id]);
                r.flag         = flag_before;
                r.running      = ch_enabled[w.timer_id];
                r.last         = 1'b1;
                due_words.push_back(r);
            end
        end
    endtask

    // Predict on every accepted command word, compare on every accepted result word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_TIMERS; k++)
            begin
                ch_count[k]    = '0;
                ch_reload[k]   = '0;
                ch_periodic[k] = 1'b0;
                ch_enabled[k]  = 1'b0;
                ch_flag[k]     = 1'b0;
            end
            due_words.delete();
            bad_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                apply_command(cmd_word);
            if (res_valid && res_ready)
            begin
                if (due_words.size() == 0)
                begin
                    bad_count++;
                    $display("%0t: unexpected result word: expected none, ", $time,
                             "got kind %0d id %0d value %0d flag %0b run %0b last %0b",
                             res_word.kind, res_word.timer_id_res, res_word.value,
                             res_word.flag, res_word.running, res_word.last);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (res_word !== want)
                    begin
                        bad_count++;
                        $display("%0t: result mismatch: ", $time,
                                 "expected kind %0d id %0d value %0d flag %0b run %0b last %0b, ",
                                 want.kind, want.timer_id_res, want.value,
                                 want.flag, want.running, want.last,
                                 "got kind %0d id %0d value %0d flag %0b run %0b last %0b",
                                 res_word.kind, res_word.timer_id_res, res_word.value,
                                 res_word.flag, res_word.running, res_word.last);
                    end
                end
            end
            mismatches  <= bad_count;
            outstanding <= due_words.size();
        end
    end

endmodule

@@ sim/tb_multi_channel_down_timer.sv @@
// Testbench top for the multi-channel down timer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_multi_channel_down_timer;

    import mcdt_pkg::*;

    localparam int N_CH         = 16;
    localparam int CW           = 16;
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = N_CH + 20;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_GAP      = 13;

    // Codes the block does not define; they must act as a read count.
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 4'd13;
    localparam logic [CMD_W-1:0] CMD_UNDEF_MID = 4'd14;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 4'd15;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_word_t cmd_word  = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_word_t res_word;
    int        mismatches;
    int        outstanding;
    int        sent_items = 0;

    multi_channel_down_timer #(
        .NUM_TIMERS  (N_CH),
        .COUNT_WIDTH (CW)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    timer_bank_check #(
        .NUM_TIMERS  (N_CH),
        .COUNT_WIDTH (CW)
    ) bank_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_word    (cmd_word),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_word    (res_word),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Free-running clock, 10 ns period.
    always #5 clk = ~clk;

    // Single reset pulse at the start of the run.
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic cmd_word_t make_word(input logic [CMD_W-1:0] cmd,
                                            input logic [ID_W-1:0]  id,
                                            input logic [VAL_W-1:0] tv,
                                            input logic [VAL_W-1:0] rv,
                                            input logic             per,
                                            input logic             en);
        cmd_word_t w;
        begin
            w.command      = cmd;
            w.timer_id     = id;
            w.time_value   = tv;
            w.reload_value = rv;
            w.periodic     = per;
            w.enable       = en;
            return w;
        end
    endfunction

    // Offer one command word after a random gap and hold it until accepted.
    task automatic send_word(input cmd_word_t w);
        int gap;
        begin
            if ((sent_items >= 100 && sent_items < 160) || (sent_items >= 300 && sent_items < 330))
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            cmd_valid <= 1'b1;
            cmd_word  <= w;
            @(posedge clk);
            while (!cmd_ready) @(posedge clk);
            sent_items++;
        end
    endtask

    // Result side: random stalls per word, quiet stretches, and one long hold-off.
    initial
    begin : result_sink
        int gap;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ((taken >= 250 && taken < 350) || (taken >= 600 && taken < 650))
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                res_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
            taken++;
        end
    end

    // Command side: directed opening, then random traffic, then drain and verdict.
    initial
    begin : stimulus
        cmd_word_t w;
        int        pick;
        int        random_sent;
        int        k;
        @(posedge rst_n);

        // Set up channels with the count and reload extremes, both modes, and a zero reload.
        send_word(make_word(CMD_ARM, 4'd0, 16'd1, 16'hFFFF, 1'b0, 1'b1));
        send_word(make_word(CMD_ARM, 4'd1, 16'd2, 16'd0, 1'b1, 1'b1));
        send_word(make_word(CMD_ARM, 4'd5, 16'd1, 16'd1, 1'b1, 1'b1));
        send_word(make_word(CMD_ARM, 4'd15, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
        send_word(make_word(CMD_ARM, 4'd2, 16'd1, 16'hABCD, 1'b0, 1'b0));
        send_word(make_word(CMD_TICK, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_TICK, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));

        // A word for each remaining operation, then the undefined codes and a closing tick.
        send_word(make_word(CMD_READ_COUNT, 4'd1, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_READ_FLAG, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_READ_CLEAR, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_CLEAR_FLAG, 4'd5, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_READ_ENABLE, 4'd2, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_SET_RELOAD, 4'd0, 16'h1234, 16'hFFFF, 1'b0, 1'b0));
        send_word(make_word(CMD_READ_RELOAD, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_SET_ENABLE, 4'd2, 16'd0, 16'd0, 1'b0, 1'b1));
        send_word(make_word(CMD_RESTART, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_LOAD_COUNT, 4'd7, 16'hFFFF, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_READ_COUNT, 4'd15, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_DISARM, 4'd15, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_UNDEF_LO, 4'd5, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        send_word(make_word(CMD_UNDEF_MID, 4'd15, 16'd0, 16'd0, 1'b0, 1'b0));
        send_word(make_word(CMD_UNDEF_HI, 4'd1, 16'h5A5A, 16'hA5A5, 1'b1, 1'b0));
        send_word(make_word(CMD_TICK, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));

        // Random traffic: mostly arm/tick sequences with short counts, plus noise.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            w.command      = CMD_TICK;
            w.timer_id     = ID_W'($urandom);
            w.time_value   = VAL_W'($urandom);
            w.reload_value = VAL_W'($urandom);
            w.periodic     = 1'($urandom);
            w.enable       = 1'($urandom);
            if (pick < 3)
            begin
                // Arm every channel to fire on the next tick or the one after.
                for (k = 0; k < N_CH; k++)
                    send_word(make_word(CMD_ARM, ID_W'(k), VAL_W'($urandom_range(1, 2)),
                                        VAL_W'($urandom_range(0, 3)), 1'($urandom), 1'b1));
                random_sent += N_CH;
            end
            else if (pick < 35)
                w.command = CMD_TICK;
            else if (pick < 65)
            begin
                w.command = (pick < 55) ? CMD_ARM : CMD_LOAD_COUNT;
                if ($urandom_range(0, 9) != 0)
                    w.time_value = VAL_W'($urandom_range(0, 5));
                if ($urandom_range(0, 9) != 0)
                    w.reload_value = VAL_W'($urandom_range(0, 5));
                w.enable = ($urandom_range(0, 3) != 0);
            end
            else
                w.command = CMD_W'($urandom_range(CMD_SET_ENABLE, CMD_UNDEF_HI));
            send_word(w);
            random_sent++;
        end

        // Drain: wait for every owed result word, then let the block settle.
        @(negedge clk);
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_multi_channel_down_timer: done, clean");
        else
            $display("tb_multi_channel_down_timer: done, errors");
        $finish;
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_multi_channel_down_timer: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/mcdt_pkg.sv
rtl/core/mcdt_datapath.sv
rtl/core/mcdt_ctrl.sv
rtl/core/multi_channel_down_timer.sv
rtl/core/mcdt_checker.sv
sim/timer_bank_check.sv
sim/tb_multi_channel_down_timer.sv
